/* rtl/core/hcb_pkg.sv */
package hcb_pkg;

    // Fixed field widths of the stream words.
    localparam int SYM_W     = 8;
    localparam int FREQ_W    = 16;
    localparam int CODE_W    = 63;
    localparam int LEN_W     = 6;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 80;

endpackage

/* rtl/core/hcb_ram.sv */
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/huffman_code_builder.sv */
// Huffman code builder.
//
// The slave channel takes one word per symbol: tdata holds the symbol byte and
// its frequency, and tlast marks the final symbol of a run. Each accepted word
// is inserted into a weight-sorted list held in a small RAM; the insertion
// scans the list from its front, reading and then comparing each entry.
// On the word marked last the block merges the two lightest entries again and
// again (a check, the two pops and one insertion scan per merge), then walks
// the tree in preorder and sends one master word per leaf with the symbol, its
// code and the code length; m_tlast marks the final code. The list insertion
// scan dominates the time of a full run. s_tready is high only while the block
// is idle, so one word is worked on at a time. Words beyond MAX_SYMBOLS in a
// run are dropped, but a dropped word marked last still starts the build.
// The result sits in an output register; while the receiver stalls, the walk
// waits on that register and no code is lost. Reset empties the list and
// clears the output valid; RAM contents are not cleared and need not be.
module huffman_code_builder
    import hcb_pkg::*;
#(
    parameter int MAX_SYMBOLS = 64,
    parameter int FREQ_BITS   = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // symbol[7:0], frequency[23:8]
    input  logic                s_tlast,   // last symbol of the run
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // symbol[7:0], code[70:8], length[76:71], zero
    output logic                m_tlast    // final code of the run
);

    localparam int NODE_W  = $clog2(2 * MAX_SYMBOLS);
    localparam int LADDR_W = $clog2(2 * MAX_SYMBOLS);
    localparam int CNT_W   = $clog2(MAX_SYMBOLS + 1);
    localparam int LA_W    = $clog2(MAX_SYMBOLS);
    localparam int WGT_W   = FREQ_BITS + $clog2(MAX_SYMBOLS);
    localparam int FB      = (FREQ_BITS < FREQ_W) ? FREQ_BITS : FREQ_W;
    localparam int ENT_W   = NODE_W + WGT_W;
    localparam int FRM_W   = NODE_W + LEN_W + CODE_W;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [WGT_W-1:0]  weight;
    } entry_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } frame_t;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_INS_RD  = 13'b0000000000010,
        S_INS_CMP = 13'b0000000000100,
        S_BCHK    = 13'b0000000001000,
        S_BA      = 13'b0000000010000,
        S_BB      = 13'b0000000100000,
        S_BC      = 13'b0000001000000,
        S_WR      = 13'b0000010000000,
        S_WROOT   = 13'b0000100000000,
        S_WPROC   = 13'b0001000000000,
        S_WLINK   = 13'b0010000000000,
        S_WEMIT   = 13'b0100000000000,
        S_WPOP    = 13'b1000000000000
    } state_t;

    localparam logic [LADDR_W-1:0] HEAD_INIT = LADDR_W'(2 * MAX_SYMBOLS - 1);
    localparam logic [NODE_W-1:0]  NODE_MAX  = NODE_W'(MAX_SYMBOLS);

    state_t               state_reg, state_next;
    logic [LADDR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     loaded_reg, loaded_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     sp_reg, sp_next;
    logic [NODE_W-1:0]    next_node_reg, next_node_next;
    logic                 build_reg, build_next;
    logic                 last_reg, last_next;
    entry_t               new_reg, new_next;
    entry_t               a_reg, a_next;
    frame_t               cur_reg, cur_next;
    logic                 mval_reg, mval_next;
    logic [SYM_W-1:0]     msym_reg, msym_next;
    logic [CODE_W-1:0]    mcode_reg, mcode_next;
    logic [LEN_W-1:0]     mlen_reg, mlen_next;
    logic                 mlast_reg, mlast_next;

    // Sorted list RAM.
    logic                 lst_we;
    logic [LADDR_W-1:0]   lst_waddr, lst_raddr;
    entry_t               lst_wdata, lst_rdata;
    // Leaf symbol RAM.
    logic                 sym_we;
    logic [LA_W-1:0]      sym_waddr, sym_raddr;
    logic [SYM_W-1:0]     sym_wdata, sym_rdata;
    // Child link RAM, one row per internal node.
    logic                 lnk_we;
    logic [LA_W-1:0]      lnk_waddr, lnk_raddr;
    logic [2*NODE_W-1:0]  lnk_wdata, lnk_rdata;
    // Walk stack RAM holding pending right branches.
    logic                 stk_we;
    logic [LA_W-1:0]      stk_waddr, stk_raddr;
    frame_t               stk_wdata, stk_rdata;

    hcb_ram #(.WIDTH(ENT_W), .DEPTH(2 * MAX_SYMBOLS)) u_list (
        .aclk(aclk), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
        .raddr(lst_raddr), .rdata(lst_rdata)
    );
    hcb_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SYMBOLS)) u_sym (
        .aclk(aclk), .we(sym_we), .waddr(sym_waddr), .wdata(sym_wdata),
        .raddr(sym_raddr), .rdata(sym_rdata)
    );
    hcb_ram #(.WIDTH(2 * NODE_W), .DEPTH(MAX_SYMBOLS)) u_link (
        .aclk(aclk), .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
        .raddr(lnk_raddr), .rdata(lnk_rdata)
    );
    hcb_ram #(.WIDTH(FRM_W), .DEPTH(MAX_SYMBOLS)) u_stack (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    logic                 out_free;
    logic                 goes_before;
    logic [LADDR_W-1:0]   scan_addr;
    logic [LADDR_W-1:0]   slot_addr;
    logic [CODE_W-1:0]    code_shl;
    logic [LEN_W-1:0]     len_inc;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {3'b000, mlen_reg, mcode_reg, msym_reg};
    assign out_free = !mval_reg || m_tready;

    assign scan_addr = head_reg + LADDR_W'(k_reg);
    assign slot_addr = scan_addr - LADDR_W'(1);
    // The front entry lets an equal weight pass behind it; later entries do not.
    assign goes_before = (k_reg == '0) ? (new_reg.weight < lst_rdata.weight)
                                       : (new_reg.weight <= lst_rdata.weight);
    assign code_shl = {cur_reg.code[CODE_W-2:0], 1'b0};
    assign len_inc  = cur_reg.len + LEN_W'(1);

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        loaded_next    = loaded_reg;
        k_next         = k_reg;
        sp_next        = sp_reg;
        next_node_next = next_node_reg;
        build_next     = build_reg;
        last_next      = last_reg;
        new_next       = new_reg;
        a_next         = a_reg;
        cur_next       = cur_reg;
        mval_next      = mval_reg && !m_tready;
        msym_next      = msym_reg;
        mcode_next     = mcode_reg;
        mlen_next      = mlen_reg;
        mlast_next     = mlast_reg;

        lst_we    = 1'b0;
        lst_waddr = slot_addr;
        lst_wdata = new_reg;
        lst_raddr = scan_addr;
        sym_we    = 1'b0;
        sym_waddr = loaded_reg[LA_W-1:0];
        sym_wdata = s_tdata[SYM_W-1:0];
        sym_raddr = cur_reg.node[LA_W-1:0];
        lnk_we    = 1'b0;
        lnk_waddr = LA_W'(next_node_reg - NODE_MAX);
        lnk_wdata = {a_reg.node, lst_rdata.node};
        lnk_raddr = LA_W'(cur_reg.node - NODE_MAX);
        stk_we    = 1'b0;
        stk_waddr = sp_reg[LA_W-1:0];
        stk_wdata = '{node: lnk_rdata[NODE_W-1:0], len: len_inc, code: code_shl | CODE_W'(1)};
        stk_raddr = LA_W'(sp_reg - CNT_W'(1));

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    last_next      = s_tlast;
                    next_node_next = NODE_MAX;
                    build_next     = 1'b0;
                    k_next         = '0;
                    if (loaded_reg < CNT_W'(MAX_SYMBOLS)) begin
                        sym_we      = 1'b1;
                        new_next    = '{node: NODE_W'(loaded_reg),
                                        weight: WGT_W'(s_tdata[SYM_W +: FB])};
                        loaded_next = loaded_reg + CNT_W'(1);
                        state_next  = S_INS_RD;
                    end else if (s_tlast) begin
                        state_next = S_BCHK;
                    end
                end
            end
            S_INS_RD: begin
                if (k_reg == cnt_reg) begin
                    lst_we    = 1'b1;
                    head_next = head_reg - LADDR_W'(1);
                    cnt_next  = cnt_reg + CNT_W'(1);
                    if (build_reg || last_reg) begin
                        state_next = S_BCHK;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                lst_we = 1'b1;
                if (goes_before) begin
                    head_next = head_reg - LADDR_W'(1);
                    cnt_next  = cnt_reg + CNT_W'(1);
                    if (build_reg || last_reg) begin
                        state_next = S_BCHK;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    // Move the lighter entry (or an equal front entry) one slot toward the front.
                    lst_wdata  = lst_rdata;
                    k_next     = k_reg + CNT_W'(1);
                    state_next = S_INS_RD;
                end
            end
            S_BCHK: begin
                if (cnt_reg > CNT_W'(1)) begin
                    state_next = S_BA;
                end else begin
                    state_next = S_WR;
                end
            end
            S_BA: begin
                lst_raddr  = head_reg;
                state_next = S_BB;
            end
            S_BB: begin
                a_next     = lst_rdata;
                lst_raddr  = head_reg + LADDR_W'(1);
                state_next = S_BC;
            end
            S_BC: begin
                lnk_we         = 1'b1;
                new_next       = '{node: next_node_reg,
                                   weight: a_reg.weight + lst_rdata.weight};
                next_node_next = next_node_reg + NODE_W'(1);
                head_next      = head_reg + LADDR_W'(2);
                cnt_next       = cnt_reg - CNT_W'(2);
                k_next         = '0;
                build_next     = 1'b1;
                state_next     = S_INS_RD;
            end
            S_WR: begin
                lst_raddr  = head_reg;
                state_next = S_WROOT;
            end
            S_WROOT: begin
                cur_next   = '{node: lst_rdata.node, len: '0, code: '0};
                sp_next    = '0;
                state_next = S_WPROC;
            end
            S_WPROC: begin
                if (cur_reg.node < NODE_MAX) begin
                    state_next = S_WEMIT;
                end else begin
                    state_next = S_WLINK;
                end
            end
            S_WLINK: begin
                // Park the right branch and descend into the left one.
                stk_we     = 1'b1;
                sp_next    = sp_reg + CNT_W'(1);
                cur_next   = '{node: lnk_rdata[2*NODE_W-1:NODE_W], len: len_inc,
                               code: code_shl};
                state_next = S_WPROC;
            end
            S_WEMIT: begin
                if (out_free) begin
                    mval_next  = 1'b1;
                    msym_next  = sym_rdata;
                    mcode_next = cur_reg.code;
                    mlen_next  = cur_reg.len;
                    mlast_next = (sp_reg == '0);
                    if (sp_reg == '0) begin
                        loaded_next = '0;
                        cnt_next    = '0;
                        head_next   = HEAD_INIT;
                        state_next  = S_IDLE;
                    end else begin
                        sp_next    = sp_reg - CNT_W'(1);
                        state_next = S_WPOP;
                    end
                end
            end
            S_WPOP: begin
                cur_next   = stk_rdata;
                state_next = S_WPROC;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            head_reg   <= HEAD_INIT;
            cnt_reg    <= '0;
            loaded_reg <= '0;
            sp_reg     <= '0;
            mval_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            cnt_reg    <= cnt_next;
            loaded_reg <= loaded_next;
            sp_reg     <= sp_next;
            mval_reg   <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        next_node_reg <= next_node_next;
        build_reg     <= build_next;
        last_reg      <= last_next;
        new_reg       <= new_next;
        a_reg         <= a_next;
        cur_reg       <= cur_next;
        msym_reg      <= msym_next;
        mcode_reg     <= mcode_next;
        mlen_reg      <= mlen_next;
        mlast_reg     <= mlast_next;
    end

endmodule
